// ===== rtl/thq_pkg.sv =====
// Types, codes and constants for the tap/hold dual-role key qualifier.
// Used by tap_hold_ctrl_key_qualifier; depends on nothing else.
`timescale 1ns / 1ps

package thq_pkg;

	localparam int COUNT_BITS     = 16;
	localparam int CFG_BITS       = 16;
	localparam int CMP_BITS       = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
	localparam int CFG_INDEX_BITS = 2;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [CFG_BITS-1:0]   cfg_t;
	typedef logic [CMP_BITS-1:0]   cmp_t;

	typedef enum logic [1:0] {
		CMD_OWN    = 2'd0,
		CMD_OTHER  = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_LETTER  = 3'd1,
		ACT_MOD_ON  = 3'd2,
		ACT_MOD_OFF = 3'd3,
		ACT_COMBO   = 3'd4
	} action_t;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_TAP   = 5'b00010,
		PH_HOLD  = 5'b00100,
		PH_READY = 5'b01000,
		PH_DONE  = 5'b10000
	} phase_t;

	localparam logic [2:0] PHASE_CODE_IDLE  = 3'd0;
	localparam logic [2:0] PHASE_CODE_TAP   = 3'd1;
	localparam logic [2:0] PHASE_CODE_HOLD  = 3'd2;
	localparam logic [2:0] PHASE_CODE_READY = 3'd3;
	localparam logic [2:0] PHASE_CODE_DONE  = 3'd4;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_TAP_TIMEOUT  = 2'd0,
		REG_READY_TIME   = 2'd1,
		REG_RETAP_WINDOW = 2'd2
	} cfg_index_t;

	localparam cfg_t TAP_TIMEOUT_RST  = 16'd200;
	localparam cfg_t READY_TIME_RST   = 16'd500;
	localparam cfg_t RETAP_WINDOW_RST = 16'd100;

	function automatic logic [2:0] phase_code(input phase_t p);
		logic [2:0] code;
		unique case (p)
			PH_IDLE:  code = PHASE_CODE_IDLE;
			PH_TAP:   code = PHASE_CODE_TAP;
			PH_HOLD:  code = PHASE_CODE_HOLD;
			PH_READY: code = PHASE_CODE_READY;
			PH_DONE:  code = PHASE_CODE_DONE;
			default:  code = PHASE_CODE_IDLE;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/tap_hold_ctrl_key_qualifier.sv =====
// Pipeline: an accepted request is held in the input register, then its result in the
// result register that drives the outputs; the result stays until it is taken.
// One request per cycle unless the output stalls; phase and counters update in one pass.
// Reset: arst_n clears the phase to idle, both counters and the retap arm, and
// loads the timing registers with 200, 500 and 100 ticks.
// Top level; uses thq_pkg for codes, types and reset values.
`timescale 1ns / 1ps

module tap_hold_ctrl_key_qualifier (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [thq_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [thq_pkg::CFG_BITS-1:0]        cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          cmd,
	input  logic                                pressed,
	input  logic                                is_modifier,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [2:0]                          action,
	output logic                                pass_on,
	output logic [2:0]                          phase
);

	thq_pkg::cfg_t tap_timeout_q, ready_time_q, retap_window_q;

	thq_pkg::phase_t phase_q;
	thq_pkg::count_t hold_count_q, retap_count_q;
	logic            retap_armed_q;

	logic       s1_valid_q;
	logic [1:0] cmd_s1;
	logic       pressed_s1, is_modifier_s1;

	logic       out_valid_q;
	logic [2:0] action_s2, phase_s2;
	logic       pass_on_s2;

	logic advance;

	thq_pkg::phase_t  ph_n, ph_t1, ph_t2;
	thq_pkg::count_t  hc_n, rc_n, hc_inc, rc_inc;
	logic             armed_n, pass_n;
	thq_pkg::action_t act_n;

	assign advance  = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_timeout_q  <= thq_pkg::TAP_TIMEOUT_RST;
			ready_time_q   <= thq_pkg::READY_TIME_RST;
			retap_window_q <= thq_pkg::RETAP_WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				thq_pkg::REG_TAP_TIMEOUT:  tap_timeout_q  <= cfg_data;
				thq_pkg::REG_READY_TIME:   ready_time_q   <= cfg_data;
				thq_pkg::REG_RETAP_WINDOW: retap_window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1         <= cmd;
			pressed_s1     <= pressed;
			is_modifier_s1 <= is_modifier;
		end
	end

	// Counters saturate rather than wrap.
	assign hc_inc = (hold_count_q == '1) ? hold_count_q : hold_count_q + thq_pkg::count_t'(1);
	assign rc_inc = (retap_count_q == '1) ? retap_count_q : retap_count_q + thq_pkg::count_t'(1);

	always_comb begin
		ph_n    = phase_q;
		hc_n    = hold_count_q;
		rc_n    = retap_count_q;
		armed_n = retap_armed_q;
		act_n   = thq_pkg::ACT_NONE;
		pass_n  = 1'b0;
		ph_t1   = phase_q;
		ph_t2   = phase_q;
		unique case (thq_pkg::cmd_t'(cmd_s1))
			thq_pkg::CMD_OWN: begin
				if (pressed_s1) begin
					if (phase_q == thq_pkg::PH_IDLE) begin
						ph_n = thq_pkg::PH_TAP;
						hc_n = '0;
					end else if (phase_q == thq_pkg::PH_READY && retap_armed_q &&
							thq_pkg::cmp_t'(retap_count_q) <
							thq_pkg::cmp_t'(retap_window_q)) begin
						act_n   = thq_pkg::ACT_COMBO;
						ph_n    = thq_pkg::PH_DONE;
						armed_n = 1'b0;
					end else begin
						ph_n    = thq_pkg::PH_IDLE;
						armed_n = 1'b0;
					end
				end else begin
					unique case (phase_q)
						thq_pkg::PH_TAP: begin
							act_n = thq_pkg::ACT_LETTER;
							ph_n  = thq_pkg::PH_IDLE;
						end
						thq_pkg::PH_HOLD: begin
							act_n = thq_pkg::ACT_MOD_OFF;
							ph_n  = thq_pkg::PH_IDLE;
						end
						thq_pkg::PH_READY: begin
							// A release in hold ready (re)starts the retap window.
							act_n   = thq_pkg::ACT_MOD_OFF;
							rc_n    = '0;
							armed_n = 1'b1;
						end
						thq_pkg::PH_DONE: ph_n = thq_pkg::PH_IDLE;
						default: ;
					endcase
				end
			end
			thq_pkg::CMD_OTHER: begin
				pass_n = 1'b1;
				if (pressed_s1 && phase_q == thq_pkg::PH_TAP) begin
					if (is_modifier_s1) begin
						act_n = thq_pkg::ACT_MOD_ON;
						ph_n  = thq_pkg::PH_HOLD;
					end else begin
						act_n = thq_pkg::ACT_LETTER;
						ph_n  = thq_pkg::PH_IDLE;
					end
				end
			end
			thq_pkg::CMD_TICK: begin
				// One tick may walk through tap, hold and ready in order.
				hc_n = hc_inc;
				if (retap_armed_q) begin
					rc_n = rc_inc;
				end
				if (phase_q == thq_pkg::PH_TAP &&
						thq_pkg::cmp_t'(hc_inc) >= thq_pkg::cmp_t'(tap_timeout_q)) begin
					ph_t1 = thq_pkg::PH_HOLD;
					act_n = thq_pkg::ACT_MOD_ON;
				end
				ph_t2 = ph_t1;
				if (ph_t1 == thq_pkg::PH_HOLD &&
						thq_pkg::cmp_t'(hc_inc) >= thq_pkg::cmp_t'(ready_time_q)) begin
					ph_t2 = thq_pkg::PH_READY;
				end
				ph_n = ph_t2;
				if (ph_t2 == thq_pkg::PH_READY && retap_armed_q &&
						thq_pkg::cmp_t'(rc_n) >= thq_pkg::cmp_t'(retap_window_q)) begin
					ph_n    = thq_pkg::PH_IDLE;
					armed_n = 1'b0;
				end
			end
			thq_pkg::CMD_UNUSED: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= thq_pkg::PH_IDLE;
			hold_count_q  <= '0;
			retap_count_q <= '0;
			retap_armed_q <= 1'b0;
		end else if (advance) begin
			phase_q       <= ph_n;
			hold_count_q  <= hc_n;
			retap_count_q <= rc_n;
			retap_armed_q <= armed_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_s2  <= act_n;
			pass_on_s2 <= pass_n;
			phase_s2   <= thq_pkg::phase_code(ph_n);
		end
	end

	assign out_valid = out_valid_q;
	assign action    = action_s2;
	assign pass_on   = pass_on_s2;
	assign phase     = phase_s2;

`ifndef ASSERT_OFF
	a_armed_only_ready: assert property (@(posedge clk) disable iff (!arst_n)
		retap_armed_q |-> phase_q == thq_pkg::PH_READY)
		else $error("retap window armed outside hold ready");

	a_pass_actions: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && pass_on_s2) |->
			(action_s2 != thq_pkg::ACT_MOD_OFF && action_s2 != thq_pkg::ACT_COMBO))
		else $error("other-key request produced an own-key action");

	a_mod_on_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && action_s2 == thq_pkg::ACT_MOD_ON) |->
			(phase_s2 == thq_pkg::PHASE_CODE_HOLD || phase_s2 == thq_pkg::PHASE_CODE_READY))
		else $error("modifier press reported outside a hold phase");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (s1_valid_q && out_valid_q && !out_ready))
		else $error("input stalled with room in the pipeline");
`endif

endmodule
